// ----- src/fcv_pkg.sv -----
// ----------------------------------------------------------------------------
// fcv_pkg
// Shared types, constants and the 16-bit carry fold for the frame checksum
// verifier.
// ----------------------------------------------------------------------------
`default_nettype none

package fcv_pkg;

  localparam int unsigned NUM_PORTS = 16;
  localparam int unsigned HALF_W    = 16;
  localparam int unsigned PORT_IDX_W = 4;

  typedef enum logic [1:0] {
    VERDICT_DELIVERED = 2'd0,
    VERDICT_BAD_SUM   = 2'd1,
    VERDICT_CLOSED    = 2'd2
  } verdict_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [HALF_W-1:0] forward_checksum;
  } judgement_t;

  // Fold a sum of up to three 16-bit terms back to 16 bits.
  function automatic logic [HALF_W-1:0] fold16(input logic [HALF_W+1:0] s);
    logic [HALF_W:0] first;
    logic [HALF_W:0] second;
    first  = {1'b0, s[HALF_W-1:0]} + {15'b0, s[HALF_W+1:HALF_W]};
    second = {1'b0, first[HALF_W-1:0]} + {16'b0, first[HALF_W]};
    return second[HALF_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/fcv_judge.sv -----
// ----------------------------------------------------------------------------
// fcv_judge
// Finishes the checksum of the last word and decides delivery, checksum
// error or closed port.
// ----------------------------------------------------------------------------
`default_nettype none

module fcv_judge (
  input  wire logic [15:0]            payload,
  input  wire logic [15:0]            port_number,
  input  wire logic [15:0]            msg_number,
  input  wire logic [15:0]            received_checksum,
  input  wire logic [15:0]            port_open_mask,
  output fcv_pkg::judgement_t         judgement
);
  import fcv_pkg::*;

  logic [HALF_W-1:0]     full;
  logic [HALF_W-1:0]     calc;
  logic [PORT_IDX_W-1:0] port_idx;
  logic [HALF_W-1:0]     port_minus_one;
  logic                  port_in_range;

  assign full = fold16({2'b00, payload} + {2'b00, port_number} + {2'b00, msg_number});
  assign calc = ~full;
  assign port_minus_one = port_number - 16'd1;
  assign port_idx = port_minus_one[PORT_IDX_W-1:0];
  assign port_in_range = (port_number != 16'd0) && (port_number <= HALF_W'(NUM_PORTS));

  always_comb begin
    judgement.forward_checksum = ~payload;
    if (calc != received_checksum) begin
      judgement.verdict = VERDICT_BAD_SUM;
    end else if (!port_in_range) begin
      judgement.verdict = VERDICT_CLOSED;
    end else if (port_open_mask[port_idx]) begin
      judgement.verdict = VERDICT_DELIVERED;
    end else begin
      judgement.verdict = VERDICT_CLOSED;
    end
  end

endmodule

`default_nettype wire

// ----- src/frame_checksum_verify_route.sv -----
// ----------------------------------------------------------------------------
// frame_checksum_verify_route
// Frame checksum verifier and port router.
// ----------------------------------------------------------------------------
// Takes one 32-bit payload word per cycle while not stalled and keeps a
// folded 16-bit ones' complement sum of its halves. On the word flagged last
// it adds port and message number, checks the complemented fold against the
// received checksum and emits one verdict with the payload-only checksum and
// the port. An accepted word is loaded into the input register; when it is
// the last word, its verdict is then loaded into the result register.
// Throughput is one word per cycle while the input is not stalled; the
// running-sum register closes the only loop. The input stalls only while a
// last word waits in the input register behind a stalled result. The
// port-open bitmap is written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_checksum_verify_route (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        word_valid,
  output logic             word_stall,
  input  wire logic [31:0] payload_word,
  input  wire logic [15:0] port_number,
  input  wire logic [15:0] msg_number,
  input  wire logic [15:0] received_checksum,
  input  wire logic        last_word,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       verdict,
  output logic [15:0]      forward_checksum,
  output logic [15:0]      port_echo
);
  import fcv_pkg::*;

  logic [HALF_W-1:0] port_open_mask;
  logic [HALF_W-1:0] payload_sum;

  logic              s1_valid;
  logic [31:0]       s1_word;
  logic [15:0]       s1_port;
  logic [15:0]       s1_msg;
  logic [15:0]       s1_rcv;
  logic              s1_last;

  logic              s1_advance;
  logic              word_accept;
  logic [HALF_W-1:0] payload;
  judgement_t        judgement;

  assign cfg_ready = 1'b1;

  assign s1_advance  = s1_valid && (!s1_last || !result_valid || !result_stall);
  assign word_stall  = s1_valid && !s1_advance;
  assign word_accept = word_valid && !word_stall;

  assign payload = fold16({2'b00, payload_sum} + {2'b00, s1_word[15:0]}
                          + {2'b00, s1_word[31:16]});

  fcv_judge u_judge (
    .payload           (payload),
    .port_number       (s1_port),
    .msg_number        (s1_msg),
    .received_checksum (s1_rcv),
    .port_open_mask    (port_open_mask),
    .judgement         (judgement)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      port_open_mask <= '0;
      payload_sum    <= '0;
      s1_valid       <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        port_open_mask <= cfg_data;
      end
      if (s1_advance) begin
        payload_sum <= s1_last ? '0 : payload;
      end
      if (word_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance && s1_last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (word_accept) begin
      s1_word <= payload_word;
      s1_port <= port_number;
      s1_msg  <= msg_number;
      s1_rcv  <= received_checksum;
      s1_last <= last_word;
    end
    if (s1_advance && s1_last) begin
      verdict          <= judgement.verdict;
      forward_checksum <= judgement.forward_checksum;
      port_echo        <= s1_port;
    end
  end

  a_sum_clears: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_last |=> payload_sum == '0)
    else $error("running sum not cleared after last word");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    word_stall |-> s1_valid && s1_last && result_valid)
    else $error("input stalled without a blocked last word");

  a_delivered_in_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && verdict == VERDICT_DELIVERED
      |-> port_echo != 16'd0 && port_echo <= 16'(NUM_PORTS))
    else $error("delivered verdict for out-of-range port");

  a_result_from_s1: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(s1_valid) && $past(s1_last))
    else $error("result without a last word in the input register");

endmodule

`default_nettype wire
